>>> hdl/pcr_pkg.sv
package pcr_pkg;

   // defaults for top-level parameters
   localparam int POLE_PAIRS_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_POWER   = 3'd0,
      CSR_MAX_TORQUE  = 3'd1,
      CSR_NOMINAL_VDC = 3'd2,
      CSR_BACK_EMF    = 3'd3,
      CSR_FLUX        = 3'd4,
      CSR_MAX_CURRENT = 3'd5,
      CSR_FW_START    = 3'd6,
      CSR_FW_FULL     = 3'd7
   } pcr_csr_type;

   // fixed-point constants
   localparam logic [19:0] THIRTY_OVER_PI_Q16 = 20'd625823;
   localparam logic [15:0] INV_SQRT3_Q16      = 16'd37837;
   localparam logic [30:0] VPH_FLOOR_Q16      = 31'd6554;
   localparam logic [30:0] MAX31              = 31'h7FFF_FFFF;
   localparam logic [31:0] INDEX_SAT          = 32'h8000_0000;

   // register reset values
   localparam logic [19:0] RST_MAX_POWER   = 20'd1000;
   localparam logic [30:0] RST_MAX_TORQUE  = 31'd65536;
   localparam logic [30:0] RST_NOMINAL_VDC = 31'd65536;
   localparam logic [31:0] RST_BACK_EMF    = 32'd0;
   localparam logic [31:0] RST_FLUX        = 32'd16777216;
   localparam logic [30:0] RST_MAX_CURRENT = 31'd0;
   localparam logic [30:0] RST_FW_START    = 31'd65536;
   localparam logic [30:0] RST_FW_FULL     = 31'd131072;

   typedef struct packed {
      logic signed [31:0] elec_speed;
      logic        [30:0] dc_link_voltage;
      logic signed [31:0] torque_request;
   } pcr_req_type;

   typedef struct packed {
      logic        [30:0] torque_limit;
      logic signed [31:0] torque_ref_limited;
      logic signed [31:0] d_current_ref;
      logic signed [31:0] q_current_ref;
   } pcr_rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [31:0] w_mag;
      logic [30:0] vdc;
      logic        tq_neg;
      logic [31:0] tq_mag;
   } pcr_item_type;

   typedef struct packed {
      logic [19:0] max_power;
      logic [30:0] max_torque;
      logic [30:0] nominal_dc_voltage;
      logic [31:0] back_emf_constant;
      logic [31:0] flux_linkage;
      logic [30:0] max_current;
      logic [30:0] fw_start_index;
      logic [30:0] fw_full_index;
   } pcr_cfg_type;

   // queue status between front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } pcr_qstat_type;

endpackage

>>> hdl/pmsm_current_reference_top.sv
// Throughput: one word per cycle while the response side does not stall; every
//   divider and the square root are pipelined one result bit per stage, so no
//   unit is reused across items.
// Reset: synchronous, active high; clears the queue, all stage valid bits and the
//   response valid, and loads the configuration registers with their defaults.
module pmsm_current_reference_top #(
   parameter int POLE_PAIRS  = pcr_pkg::POLE_PAIRS_DEF,
   parameter int QUEUE_DEPTH = pcr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pcr_pkg::pcr_req_type               req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pcr_pkg::pcr_rsp_type               rsp_data,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [pcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers. The user must write them only while the pipe is empty;
   // the block does not enforce this. Every stage reads them directly instead of carrying a copy per word.
   pcr_pkg::pcr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pcr_pkg::pcr_csr_type'(csr_index))
            pcr_pkg::CSR_MAX_POWER:   cfg_in.max_power          = csr_wdata[19:0];
            pcr_pkg::CSR_MAX_TORQUE:  cfg_in.max_torque         = csr_wdata[30:0];
            pcr_pkg::CSR_NOMINAL_VDC: cfg_in.nominal_dc_voltage = csr_wdata[30:0];
            pcr_pkg::CSR_BACK_EMF:    cfg_in.back_emf_constant  = csr_wdata;
            pcr_pkg::CSR_FLUX:        cfg_in.flux_linkage       = csr_wdata;
            pcr_pkg::CSR_MAX_CURRENT: cfg_in.max_current        = csr_wdata[30:0];
            pcr_pkg::CSR_FW_START:    cfg_in.fw_start_index     = csr_wdata[30:0];
            pcr_pkg::CSR_FW_FULL:     cfg_in.fw_full_index      = csr_wdata[30:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_power          <= pcr_pkg::RST_MAX_POWER;
         cfg_ff.max_torque         <= pcr_pkg::RST_MAX_TORQUE;
         cfg_ff.nominal_dc_voltage <= pcr_pkg::RST_NOMINAL_VDC;
         cfg_ff.back_emf_constant  <= pcr_pkg::RST_BACK_EMF;
         cfg_ff.flux_linkage       <= pcr_pkg::RST_FLUX;
         cfg_ff.max_current        <= pcr_pkg::RST_MAX_CURRENT;
         cfg_ff.fw_start_index     <= pcr_pkg::RST_FW_START;
         cfg_ff.fw_full_index      <= pcr_pkg::RST_FW_FULL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take request words, fold signs into magnitudes, push to the queue.
   pcr_pkg::pcr_qstat_type q_stat;
   pcr_pkg::pcr_item_type  push_data;
   pcr_pkg::pcr_item_type  pop_data;
   logic                   push;
   logic                   pop;

   pcr_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // Queue: decouples the request side from response back-pressure.
   pcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // Back: torque limit, modulation index, d/q references; advances as one pipe
   // whenever the response register is empty or being taken.
   pcr_back #(
      .POLE_PAIRS (POLE_PAIRS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/pcr_front.sv
module pcr_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcr_pkg::pcr_req_type  req_data,
   input  pcr_pkg::pcr_qstat_type q_stat,
   output logic                  push,
   output pcr_pkg::pcr_item_type push_data
);

   logic [31:0] speed_bits;
   logic [31:0] torque_bits;

   assign speed_bits  = req_data.elec_speed;
   assign torque_bits = req_data.torque_request;

   // hold the requester off while the queue is full
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      push_data.w_mag  = speed_bits[31] ? (32'd0 - speed_bits) : speed_bits;
      push_data.vdc    = req_data.dc_link_voltage;
      push_data.tq_neg = torque_bits[31];
      push_data.tq_mag = torque_bits[31] ? (32'd0 - torque_bits) : torque_bits;
   end

endmodule

>>> hdl/pcr_queue.sv
module pcr_queue #(
   parameter int DEPTH = pcr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pcr_pkg::pcr_item_type  push_data,
   input  logic                   pop,
   output pcr_pkg::pcr_item_type  pop_data,
   output pcr_pkg::pcr_qstat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcr_pkg::pcr_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop           = pop && (count_ff != '0);
   assign pop_data         = entry_ff[rd_ptr_ff];
   assign q_stat.full      = (count_ff == CNT_W'(DEPTH));
   assign q_stat.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/pcr_div.sv
module pcr_div #(
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 31,
   parameter int Q_W    = 31,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // one quotient bit per stage, most significant first
   localparam int CW = NUM_W + DEN_W;

   logic              vld_ff  [Q_W];
   logic [NUM_W-1:0]  rem_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [Q_W-1:0]    quo_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int BIT = Q_W - 1 - k;
      logic              vld_prev;
      logic [NUM_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = in_num;
         assign den_prev  = in_den;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign ge = (CW'(rem_prev >> BIT) >= CW'(den_prev));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? (rem_prev - NUM_W'(CW'(den_prev) << BIT)) : rem_prev;
            den_ff[k]  <= den_prev;
            quo_ff[k]  <= (quo_prev << 1) | Q_W'(ge);
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[Q_W-1];
   assign out_quo  = quo_ff[Q_W-1];
   assign out_side = side_ff[Q_W-1];

endmodule

>>> hdl/pcr_isqrt.sv
module pcr_isqrt #(
   parameter int RAD_W  = 62,
   parameter int ROOT_W = 31,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   // one root bit per stage; rem holds radicand minus root squared
   localparam int CW = RAD_W + 2;

   logic              vld_ff  [ROOT_W];
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - k;
      logic              vld_prev;
      logic [RAD_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [CW-1:0]     step;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = in_rad;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign step = (CW'(root_prev) << (BIT + 1)) | (CW'(1) << (2 * BIT));
      assign ge   = (CW'(rem_prev) >= step);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? (rem_prev - RAD_W'(step)) : rem_prev;
            root_ff[k] <= ge ? (root_prev | (ROOT_W'(1) << BIT)) : root_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

>>> hdl/pcr_back.sv
module pcr_back #(
   parameter int POLE_PAIRS = pcr_pkg::POLE_PAIRS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pcr_pkg::pcr_cfg_type   cfg,
   input  pcr_pkg::pcr_qstat_type q_stat,
   input  pcr_pkg::pcr_item_type  q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pcr_pkg::pcr_rsp_type   rsp_data
);

   localparam int PP_W    = $clog2(POLE_PAIRS + 1);
   localparam int PMUL_W  = 20 + PP_W;
   localparam int PMAX_W  = PMUL_W + 32;
   localparam int WT_W    = 63;
   localparam int CMP1_W  = (PMAX_W > WT_W) ? PMAX_W : WT_W;
   localparam int RPM_W   = 36;
   localparam int DEN3_W  = 32 + $clog2(3 * POLE_PAIRS + 1);
   localparam int NUM3_W  = 56;
   localparam int CMP3_W  = DEN3_W + 31;
   // reciprocal of the pole pairs, exact for every 36-bit dividend
   localparam int          RCP_K = RPM_W + $clog2(POLE_PAIRS);
   localparam logic [63:0] RCP_M = ((64'd1 << RCP_K) + 64'(POLE_PAIRS) - 64'd1)
                                   / 64'(POLE_PAIRS);

   typedef struct packed {
      logic              sel;
      logic [RPM_W-1:0]  rpm_hi;
      logic [30:0]       vph;
      logic [30:0]       vdc;
      logic              neg;
      logic [31:0]       tq;
   } side1_type;

   typedef struct packed {
      logic              ov;
      logic              zero;
      logic [RPM_W-1:0]  rpm_hi;
      logic [30:0]       vph;
      logic              neg;
      logic [31:0]       tq;
   } side2_type;

   typedef struct packed {
      logic [30:0] lim;
      logic [30:0] sat;
      logic        neg;
      logic [30:0] vph;
   } side3_type;

   typedef struct packed {
      logic        ov;
      logic [30:0] lim;
      logic [30:0] sat;
      logic        neg;
   } side4_type;

   typedef struct packed {
      logic        above;
      logic        ramp;
      logic [30:0] lim;
      logic [30:0] sat;
      logic        neg;
   } side5_type;

   typedef struct packed {
      logic        above;
      logic [30:0] d;
      logic [30:0] lim;
      logic [30:0] sat;
      logic        neg;
   } side6_type;

   typedef struct packed {
      logic        ov;
      logic [30:0] qlim;
      logic [30:0] d;
      logic [30:0] lim;
      logic [30:0] sat;
      logic        neg;
   } side7_type;

   logic adv;

   // the whole pipe moves when the output register is free or drains
   assign adv   = !rsp_valid || !rsp_stall;
   assign q_pop = adv;

   // config-derived terms; the user must keep them stable while items are in flight (unenforced)
   logic [PMAX_W-1:0] pmax;
   logic [DEN3_W-1:0] den3;
   logic [30:0]       span;

   assign pmax = {PMUL_W'(cfg.max_power) * PMUL_W'(POLE_PAIRS), 32'd0};
   assign den3 = DEN3_W'(cfg.flux_linkage) * DEN3_W'(3 * POLE_PAIRS);
   assign span = cfg.fw_full_index - cfg.fw_start_index;

   // ---- stage A: products from the raw magnitudes
   logic             a_vld_ff;
   logic [31:0]      a_wmag_ff;
   logic [30:0]      a_vdc_ff;
   logic             a_neg_ff;
   logic [31:0]      a_tq_ff;
   logic [WT_W-1:0]  a_pwt_ff;
   logic [51:0]      a_rpm_ff;
   logic [46:0]      a_vph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= q_stat.not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_wmag_ff <= q_data.w_mag;
         a_vdc_ff  <= q_data.vdc;
         a_neg_ff  <= q_data.tq_neg;
         a_tq_ff   <= q_data.tq_mag;
         a_pwt_ff  <= WT_W'(q_data.w_mag) * WT_W'(cfg.max_torque);
         a_rpm_ff  <= 52'(q_data.w_mag) * 52'(pcr_pkg::THIRTY_OVER_PI_Q16);
         a_vph_ff  <= 47'(q_data.vdc) * 47'(pcr_pkg::INV_SQRT3_Q16);
      end
   end

   // ---- D1: power-limited base torque
   side1_type        s1_in, s1_out;
   logic [30:0]      vph_raw;
   logic             d1_vld;
   logic [30:0]      d1_quo;
   logic [$bits(side1_type)-1:0] d1_side;

   assign vph_raw = a_vph_ff[46:16];

   always_comb begin
      s1_in.sel    = CMP1_W'(a_pwt_ff) <= CMP1_W'(pmax);
      s1_in.rpm_hi = a_rpm_ff[51:16];
      s1_in.vph    = (vph_raw == '0) ? pcr_pkg::VPH_FLOOR_Q16 : vph_raw;
      s1_in.vdc    = a_vdc_ff;
      s1_in.neg    = a_neg_ff;
      s1_in.tq     = a_tq_ff;
   end

   pcr_div #(.NUM_W(PMAX_W), .DEN_W(32), .Q_W(31), .SIDE_W($bits(side1_type))) u_div_base (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(a_vld_ff), .in_num(pmax), .in_den(a_wmag_ff), .in_side(s1_in),
      .out_vld(d1_vld), .out_quo(d1_quo), .out_side(d1_side)
   );

   assign s1_out = side1_type'(d1_side);

   // ---- stage B: base torque times bus voltage
   logic             b_vld_ff;
   logic [61:0]      b_prod_ff;
   logic [RPM_W-1:0] b_rpm_ff;
   logic [30:0]      b_vph_ff;
   logic             b_neg_ff;
   logic [31:0]      b_tq_ff;
   logic [30:0]      base;

   assign base = s1_out.sel ? cfg.max_torque : d1_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= d1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_prod_ff <= 62'(base) * 62'(s1_out.vdc);
         b_rpm_ff  <= s1_out.rpm_hi;
         b_vph_ff  <= s1_out.vph;
         b_neg_ff  <= s1_out.neg;
         b_tq_ff   <= s1_out.tq;
      end
   end

   // ---- D2: scale by nominal bus voltage, saturate
   side2_type        s2_in, s2_out;
   logic             d2_vld;
   logic [30:0]      d2_quo;
   logic [$bits(side2_type)-1:0] d2_side;

   always_comb begin
      s2_in.ov     = (b_prod_ff[61:31] >= cfg.nominal_dc_voltage) && (b_prod_ff != '0);
      s2_in.zero   = (b_prod_ff == '0);
      s2_in.rpm_hi = b_rpm_ff;
      s2_in.vph    = b_vph_ff;
      s2_in.neg    = b_neg_ff;
      s2_in.tq     = b_tq_ff;
   end

   pcr_div #(.NUM_W(62), .DEN_W(31), .Q_W(31), .SIDE_W($bits(side2_type))) u_div_lim (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(b_vld_ff), .in_num(b_prod_ff), .in_den(cfg.nominal_dc_voltage),
      .in_side(s2_in),
      .out_vld(d2_vld), .out_quo(d2_quo), .out_side(d2_side)
   );

   assign s2_out = side2_type'(d2_side);

   // ---- D3: mechanical rpm, divide by pole pairs (reciprocal multiply, two stages)
   side3_type        s3_in, s3_out;
   logic             d3_vld;
   logic [RPM_W-1:0] d3_quo;
   logic [17:0]      rpm_hi_h;
   logic [17:0]      rpm_hi_l;
   logic [18:0]      rcp_hi;
   logic [17:0]      rcp_lo;
   logic             r_vld_ff;
   side3_type        r_side_ff;
   logic [36:0]      r_hh_ff;
   logic [35:0]      r_hl_ff;
   logic [36:0]      r_lh_ff;
   logic [35:0]      r_ll_ff;
   logic [73:0]      r_sum;
   logic             d3_vld_ff;
   logic [RPM_W-1:0] d3_quo_ff;
   side3_type        s3_out_ff;

   always_comb begin
      s3_in.lim = s2_out.ov ? pcr_pkg::MAX31 : (s2_out.zero ? '0 : d2_quo);
      s3_in.sat = (s2_out.tq > 32'(s3_in.lim)) ? s3_in.lim : s2_out.tq[30:0];
      s3_in.neg = s2_out.neg;
      s3_in.vph = s2_out.vph;
   end

   assign rpm_hi_h = s2_out.rpm_hi[35:18];
   assign rpm_hi_l = s2_out.rpm_hi[17:0];
   assign rcp_hi   = RCP_M[36:18];
   assign rcp_lo   = RCP_M[17:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff  <= 1'b0;
         d3_vld_ff <= 1'b0;
      end else if (adv) begin
         r_vld_ff  <= d2_vld;
         d3_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_hh_ff   <= 37'(rpm_hi_h) * 37'(rcp_hi);
         r_hl_ff   <= 36'(rpm_hi_h) * 36'(rcp_lo);
         r_lh_ff   <= 37'(rpm_hi_l) * 37'(rcp_hi);
         r_ll_ff   <= 36'(rpm_hi_l) * 36'(rcp_lo);
         r_side_ff <= s3_in;
         d3_quo_ff <= RPM_W'(r_sum >> RCP_K);
         s3_out_ff <= r_side_ff;
      end
   end

   assign r_sum = 74'({r_hh_ff, 36'd0}) + (74'(r_hl_ff) << 18) + (74'(r_lh_ff) << 18)
                + 74'(r_ll_ff);

   assign d3_vld = d3_vld_ff;
   assign d3_quo = d3_quo_ff;
   assign s3_out = s3_out_ff;

   // ---- stage C: back-EMF partial products (Ke split in halves)
   logic         c_vld_ff;
   logic [51:0]  c_hi_ff;
   logic [51:0]  c_lo_ff;
   logic [30:0]  c_lim_ff;
   logic [30:0]  c_sat_ff;
   logic         c_neg_ff;
   logic [30:0]  c_vph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= d3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_hi_ff  <= 52'(d3_quo) * 52'(cfg.back_emf_constant[31:16]);
         c_lo_ff  <= 52'(d3_quo) * 52'(cfg.back_emf_constant[15:0]);
         c_lim_ff <= s3_out.lim;
         c_sat_ff <= s3_out.sat;
         c_neg_ff <= s3_out.neg;
         c_vph_ff <= s3_out.vph;
      end
   end

   // ---- D4: modulation index, saturated above any threshold
   side4_type    s4_in, s4_out;
   logic [52:0]  emf_sum;
   logic [44:0]  emf;
   logic         d4_vld;
   logic [30:0]  d4_quo;
   logic [$bits(side4_type)-1:0] d4_side;

   assign emf_sum = 53'(c_hi_ff) + 53'(c_lo_ff >> 16);
   assign emf     = emf_sum[52:8];

   always_comb begin
      s4_in.ov  = 46'(emf) >= {c_vph_ff, 15'd0};
      s4_in.lim = c_lim_ff;
      s4_in.sat = c_sat_ff;
      s4_in.neg = c_neg_ff;
   end

   pcr_div #(.NUM_W(61), .DEN_W(31), .Q_W(31), .SIDE_W($bits(side4_type))) u_div_index (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(c_vld_ff), .in_num({emf, 16'd0}), .in_den(c_vph_ff), .in_side(s4_in),
      .out_vld(d4_vld), .out_quo(d4_quo), .out_side(d4_side)
   );

   assign s4_out = side4_type'(d4_side);

   // ---- stage E: classify the index against the weakening band
   logic [31:0] m_idx;
   logic [31:0] over;
   logic        above;
   logic        d_full;
   logic        e_vld_ff;
   logic [61:0] e_prod_ff;
   logic        e_above_ff;
   logic        e_ramp_ff;
   logic [30:0] e_lim_ff;
   logic [30:0] e_sat_ff;
   logic        e_neg_ff;

   assign m_idx  = s4_out.ov ? pcr_pkg::INDEX_SAT : {1'b0, d4_quo};
   assign above  = m_idx > {1'b0, cfg.fw_start_index};
   assign over   = m_idx - {1'b0, cfg.fw_start_index};
   assign d_full = (cfg.fw_full_index <= cfg.fw_start_index) || (over >= {1'b0, span});

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d4_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_prod_ff  <= 62'(cfg.max_current) * 62'(over[30:0]);
         e_above_ff <= above;
         e_ramp_ff  <= above && !d_full;
         e_lim_ff   <= s4_out.lim;
         e_sat_ff   <= s4_out.sat;
         e_neg_ff   <= s4_out.neg;
      end
   end

   // ---- D5: linear d-current ramp
   side5_type    s5_in, s5_out;
   logic         d5_vld;
   logic [30:0]  d5_quo;
   logic [$bits(side5_type)-1:0] d5_side;

   always_comb begin
      s5_in.above = e_above_ff;
      s5_in.ramp  = e_ramp_ff;
      s5_in.lim   = e_lim_ff;
      s5_in.sat   = e_sat_ff;
      s5_in.neg   = e_neg_ff;
   end

   pcr_div #(.NUM_W(62), .DEN_W(31), .Q_W(31), .SIDE_W($bits(side5_type))) u_div_ramp (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(e_vld_ff), .in_num(e_prod_ff), .in_den(span), .in_side(s5_in),
      .out_vld(d5_vld), .out_quo(d5_quo), .out_side(d5_side)
   );

   assign s5_out = side5_type'(d5_side);

   // ---- stage F: squares for the current circle
   logic [30:0] d_mag;
   logic        f_vld_ff;
   logic [61:0] f_dsq_ff;
   logic [61:0] f_isq_ff;
   logic        f_above_ff;
   logic [30:0] f_d_ff;
   logic [30:0] f_lim_ff;
   logic [30:0] f_sat_ff;
   logic        f_neg_ff;

   assign d_mag = !s5_out.above ? '0 : (s5_out.ramp ? d5_quo : cfg.max_current);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= d5_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_dsq_ff   <= 62'(d_mag) * 62'(d_mag);
         f_isq_ff   <= 62'(cfg.max_current) * 62'(cfg.max_current);
         f_above_ff <= s5_out.above;
         f_d_ff     <= d_mag;
         f_lim_ff   <= s5_out.lim;
         f_sat_ff   <= s5_out.sat;
         f_neg_ff   <= s5_out.neg;
      end
   end

   // ---- SQ: remaining q headroom
   side6_type    s6_in, s6_out;
   logic         sq_vld;
   logic [30:0]  sq_root;
   logic [$bits(side6_type)-1:0] sq_side;

   always_comb begin
      s6_in.above = f_above_ff;
      s6_in.d     = f_d_ff;
      s6_in.lim   = f_lim_ff;
      s6_in.sat   = f_sat_ff;
      s6_in.neg   = f_neg_ff;
   end

   pcr_isqrt #(.RAD_W(62), .ROOT_W(31), .SIDE_W($bits(side6_type))) u_isqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(f_vld_ff), .in_rad(f_isq_ff - f_dsq_ff), .in_side(s6_in),
      .out_vld(sq_vld), .out_root(sq_root), .out_side(sq_side)
   );

   assign s6_out = side6_type'(sq_side);

   // ---- D6: nominal q current from torque over flux
   side7_type          s7_in, s7_out;
   logic [NUM3_W-1:0]  num3;
   logic               d6_vld;
   logic [30:0]        d6_quo;
   logic [$bits(side7_type)-1:0] d6_side;

   assign num3 = {s6_out.sat, 25'd0};

   always_comb begin
      s7_in.ov   = (CMP3_W'(num3) >= {den3, 31'd0}) && (s6_out.sat != '0);
      s7_in.qlim = s6_out.above ? sq_root : cfg.max_current;
      s7_in.d    = s6_out.d;
      s7_in.lim  = s6_out.lim;
      s7_in.sat  = s6_out.sat;
      s7_in.neg  = s6_out.neg;
   end

   pcr_div #(.NUM_W(NUM3_W), .DEN_W(DEN3_W), .Q_W(31), .SIDE_W($bits(side7_type))) u_div_inom (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(sq_vld), .in_num(num3), .in_den(den3), .in_side(s7_in),
      .out_vld(d6_vld), .out_quo(d6_quo), .out_side(d6_side)
   );

   assign s7_out = side7_type'(d6_side);

   // ---- output register
   logic                 rsp_valid_ff;
   pcr_pkg::pcr_rsp_type rsp_data_ff, rsp_data_in;
   logic [30:0]          q_mag;

   // zero torque gives zero q current, also when the flux term is zero
   assign q_mag = (s7_out.sat == '0) ? '0
                : ((s7_out.ov || (d6_quo > s7_out.qlim)) ? s7_out.qlim : d6_quo);

   always_comb begin
      rsp_data_in.torque_limit       = s7_out.lim;
      rsp_data_in.torque_ref_limited = s7_out.neg ? (32'd0 - 32'(s7_out.sat))
                                                  : 32'(s7_out.sat);
      rsp_data_in.d_current_ref      = 32'd0 - 32'(s7_out.d);
      rsp_data_in.q_current_ref      = s7_out.neg ? (32'd0 - 32'(q_mag)) : 32'(q_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d6_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
